>>> design/int8_tile_matmul_unit_defines.svh
// ----------------------------------------------------------------------------
// int8 tile matmul unit assertion macros
// assertion forms for the checker file
// ----------------------------------------------------------------------------
`ifndef INT8_TILE_MATMUL_UNIT_DEFINES_SVH
`define INT8_TILE_MATMUL_UNIT_DEFINES_SVH

// property checked at every edge outside reset
`define I8TM_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("i8tm assertion failed");

// property that must also hold while reset is applied
`define I8TM_ASSERT_NR(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("i8tm reset assertion failed");

`endif

>>> design/i8tm_pkg.sv
// ----------------------------------------------------------------------------
// i8tm_pkg
// field widths, command kinds and register codes of the int8 tile unit
// ----------------------------------------------------------------------------
package i8tm_pkg;

	localparam int KIND_W  = 3;
	localparam int TILE_W  = 3;
	localparam int ROW_W   = 4;
	localparam int WORD_W  = 3;
	localparam int DATA_W  = 64;
	localparam int MASK_W  = 8;

	localparam int ROWS_CFG_W  = 40;
	localparam int BYTES_CFG_W = 56;
	localparam int START_W     = 4;
	localparam int ROWS_FLD_W  = 5;
	localparam int BYTES_FLD_W = 7;

	localparam int PADDR_W = 5;
	localparam int PDATA_W = 64;

	localparam logic [KIND_W-1:0] KIND_CLEAR_ALL = 3'd0;
	localparam logic [KIND_W-1:0] KIND_ZERO_TILE = 3'd1;
	localparam logic [KIND_W-1:0] KIND_LOAD      = 3'd2;
	localparam logic [KIND_W-1:0] KIND_READ      = 3'd3;
	localparam logic [KIND_W-1:0] KIND_MUL       = 3'd4;

	localparam logic [1:0] REG_TILE_ROWS  = 2'd0;
	localparam logic [1:0] REG_ROW_BYTES  = 2'd1;
	localparam logic [1:0] REG_START_ROW  = 2'd2;

endpackage

>>> design/i8tm_ifs.sv
// ----------------------------------------------------------------------------
// i8tm channel interfaces
// command and response channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface i8tm_cmd_if;
	logic                              valid;
	logic                              ready;
	logic [i8tm_pkg::KIND_W-1:0]       kind;
	logic [i8tm_pkg::TILE_W-1:0]       tile;
	logic [i8tm_pkg::ROW_W-1:0]        row;
	logic [i8tm_pkg::WORD_W-1:0]       word;
	logic [i8tm_pkg::DATA_W-1:0]       data;
	logic                              load_start;
	logic [i8tm_pkg::TILE_W-1:0]       src_a;
	logic [i8tm_pkg::TILE_W-1:0]       src_b;

	modport source (output valid, kind, tile, row, word, data, load_start, src_a, src_b,
		input ready);
	modport sink (input valid, kind, tile, row, word, data, load_start, src_a, src_b,
		output ready);
endinterface

interface i8tm_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [i8tm_pkg::DATA_W-1:0]       read_data;
	logic [i8tm_pkg::MASK_W-1:0]       byte_valid;

	modport source (output valid, read_data, byte_valid, input ready);
	modport sink (input valid, read_data, byte_valid, output ready);
endinterface

>>> design/i8tm_dot.sv
// ----------------------------------------------------------------------------
// i8tm_dot
// two four-byte dot products, unsigned bytes of a times signed bytes of b
// ----------------------------------------------------------------------------
module i8tm_dot (
	input  logic [31:0]                   a_grp,
	input  logic [i8tm_pkg::DATA_W-1:0]   b_word,
	output logic [31:0]                   dot_lo,
	output logic [31:0]                   dot_hi
);

	logic signed [16:0] prod_lo [4];
	logic signed [16:0] prod_hi [4];
	logic signed [18:0] sum_lo;
	logic signed [18:0] sum_hi;

	always_comb begin
		for (int j = 0; j < 4; j++) begin
			prod_lo[j] = 17'($signed({1'b0, a_grp[8*j +: 8]})) *
				17'($signed(b_word[8*j +: 8]));
			prod_hi[j] = 17'($signed({1'b0, a_grp[8*j +: 8]})) *
				17'($signed(b_word[32 + 8*j +: 8]));
		end
		sum_lo = 19'(prod_lo[0]) + 19'(prod_lo[1]) + 19'(prod_lo[2]) + 19'(prod_lo[3]);
		sum_hi = 19'(prod_hi[0]) + 19'(prod_hi[1]) + 19'(prod_hi[2]) + 19'(prod_hi[3]);
	end

	assign dot_lo = 32'(sum_lo);
	assign dot_hi = 32'(sum_hi);

endmodule

>>> design/int8_tile_matmul_unit.sv
// ----------------------------------------------------------------------------
// int8_tile_matmul_unit
// tile register file with u8 x s8 dot-product multiply-accumulate
// ----------------------------------------------------------------------------
// usage
// - cmd channel: one beat per command (clear all, zero tile, load word,
//   read word, multiply); only one command is worked on at a time
// - rsp channel: one beat per read word command, data plus byte mask
// - apb port: tile_rows at 0x00, tile_row_bytes at 0x08, start_row at 0x10
// - load word: read, merge, write back to the tile memory
// - read word: read into the rsp register; the next command is taken
//   while that beat waits, a second read holds until the slot frees
// - zero tile: TILE_ROWS*ROW_WORDS words, clear all: full depth words,
//   one memory word per cycle through the single write port
// - multiply: TILE_ROWS*ROW_WORDS words of b are copied into the scratch
//   memory, then per dst row: read a and dst rows, k walk, drain, write
//   back; the k walk reads one b word per cycle from the scratch memory
// - reset: a clearing pass writes zero to every word, cmd.ready stays
//   low meanwhile, apb writes are taken as usual
// - a stalled rsp holds the one rsp register; a second read holds the block
// ----------------------------------------------------------------------------
module int8_tile_matmul_unit #(
	parameter int TILE_COUNT = 8,
	parameter int TILE_ROWS  = 16,
	parameter int ROW_BYTES  = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	i8tm_cmd_if.sink                        cmd,
	i8tm_rsp_if.source                      rsp,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [i8tm_pkg::PADDR_W-1:0]    paddr,
	input  logic [i8tm_pkg::PDATA_W-1:0]    pwdata,
	output logic [i8tm_pkg::PDATA_W-1:0]    prdata,
	output logic                            pready
);

	localparam int ROW_WORDS  = (ROW_BYTES + 7) / 8;
	localparam int TILE_WORDS = TILE_ROWS * ROW_WORDS;
	localparam int DEPTH      = TILE_COUNT * TILE_WORDS;
	localparam int AW         = $clog2(DEPTH);
	localparam int SW         = (TILE_WORDS > 1) ? $clog2(TILE_WORDS) : 1;
	localparam int WW         = (ROW_WORDS > 1) ? $clog2(ROW_WORDS) : 1;
	localparam int RW         = (TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 1;

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_LD_RD, S_LD_WR, S_RD_RD, S_RD_OUT,
		S_M_COPY, S_M_AROW, S_M_DROW, S_M_MAC, S_M_DRAIN, S_M_WB
	} state_t;

	// tag of a memory read in flight, used in the next cycle
	typedef struct packed {
		logic          vld;
		state_t        ph;
		logic [SW-1:0] cidx;
		logic [WW-1:0] widx;
		logic [RW-1:0] k;
	} tag_t;

	// configuration registers
	logic [i8tm_pkg::ROWS_CFG_W-1:0]  rows_cfg_q;
	logic [i8tm_pkg::BYTES_CFG_W-1:0] bytes_cfg_q;
	logic [i8tm_pkg::START_W-1:0]     start_q;

	state_t                      state_q;
	logic [AW-1:0]               clr_addr_q;
	logic [AW-1:0]               clr_last_q;
	logic                        then_ld_q;

	// held command fields
	logic [i8tm_pkg::TILE_W-1:0] c_tile_q;
	logic [i8tm_pkg::ROW_W-1:0]  c_row_q;
	logic [i8tm_pkg::WORD_W-1:0] c_word_q;
	logic [i8tm_pkg::DATA_W-1:0] c_data_q;

	// multiply walk
	logic [4:0]                  m_q;
	logic [4:0]                  mm_q;
	logic [4:0]                  nn_q;
	logic [4:0]                  kk_q;
	logic [AW-1:0]               b_base_q;
	logic [AW-1:0]               a_rb_q;
	logic [AW-1:0]               d_rb_q;
	logic [SW-1:0]               cp_q;
	logic [WW-1:0]               iw_q;
	logic [RW-1:0]               ik_q;

	// rsp register
	logic                        ov_q;
	logic [i8tm_pkg::DATA_W-1:0] od_q;
	logic [i8tm_pkg::MASK_W-1:0] ob_q;

	// memories and their read data registers
	logic [63:0]                 tile_mem [DEPTH];
	logic [63:0]                 scratch_mem [TILE_WORDS];
	logic [63:0]                 mem_rd_q;
	logic [63:0]                 sc_rd_q;
	logic [AW-1:0]               mem_raddr;
	logic                        mem_we;
	logic [AW-1:0]               mem_waddr;
	logic [63:0]                 mem_wdata;
	logic [SW-1:0]               sc_raddr;

	tag_t                        tag_d;
	tag_t                        tag_s1;

	// per-row operand and accumulator words of the current dst row
	logic [63:0]                 a_row_q [ROW_WORDS];
	logic [63:0]                 acc_q [ROW_WORDS];
	logic [WW-1:0]               acc_sel;
	logic [63:0]                 acc_word;
	logic [31:0]                 a_grp;
	logic [31:0]                 dot_lo;
	logic [31:0]                 dot_hi;
	logic                        lo_ok;
	logic                        hi_ok;

	// decode of the held command
	logic [4:0]                  q_rows;
	logic [6:0]                  q_bytes;
	logic                        q_row_ok;
	logic [7:0]                  q_mask;
	logic [63:0]                 q_bmask;
	logic [AW-1:0]               q_addr;

	// decode of the incoming command
	logic [4:0]                  in_rows;
	logic [6:0]                  in_dbytes;
	logic [6:0]                  in_abytes;
	logic [4:0]                  in_k;
	logic                        in_mul_ok;

	function automatic logic [4:0] rows_eff(input logic [i8tm_pkg::ROWS_CFG_W-1:0] cfg,
		input logic [2:0] t);
		logic [4:0] v;
		v = cfg[5*t +: 5];
		return (v > 5'(TILE_ROWS)) ? 5'(TILE_ROWS) : v;
	endfunction

	function automatic logic [6:0] bytes_eff(input logic [i8tm_pkg::BYTES_CFG_W-1:0] cfg,
		input logic [2:0] t);
		logic [6:0] v;
		v = cfg[7*t +: 7];
		return (v > 7'(ROW_BYTES)) ? 7'(ROW_BYTES) : v;
	endfunction

	function automatic logic tile_ok(input logic [2:0] t);
		return 5'(t) < 5'(TILE_COUNT);
	endfunction

	function automatic logic [AW-1:0] tile_base(input logic [2:0] t);
		return AW'(AW'(t) * AW'(TILE_WORDS));
	endfunction

	// apb config port, writes land on the access cycle
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_cfg_q  <= '0;
			bytes_cfg_q <= '0;
			start_q     <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[4:3])
				i8tm_pkg::REG_TILE_ROWS: rows_cfg_q  <= pwdata[i8tm_pkg::ROWS_CFG_W-1:0];
				i8tm_pkg::REG_ROW_BYTES: bytes_cfg_q <= pwdata[i8tm_pkg::BYTES_CFG_W-1:0];
				i8tm_pkg::REG_START_ROW: start_q     <= pwdata[i8tm_pkg::START_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:3])
			i8tm_pkg::REG_TILE_ROWS: prdata = 64'(rows_cfg_q);
			i8tm_pkg::REG_ROW_BYTES: prdata = 64'(bytes_cfg_q);
			i8tm_pkg::REG_START_ROW: prdata = 64'(start_q);
			default:                 prdata = '0;
		endcase
	end

	// byte mask of the held load or read word
	always_comb begin
		q_rows   = rows_eff(rows_cfg_q, c_tile_q);
		q_bytes  = bytes_eff(bytes_cfg_q, c_tile_q);
		q_row_ok = tile_ok(c_tile_q) && (c_row_q >= start_q) && (5'(c_row_q) < q_rows);
		for (int i = 0; i < 8; i++) begin
			q_mask[i]          = q_row_ok && ((7'({c_word_q, 3'b000}) + 7'(i)) < q_bytes);
			q_bmask[8*i +: 8]  = {8{q_mask[i]}};
		end
		q_addr = AW'((AW'(c_tile_q) * AW'(TILE_ROWS) + AW'(c_row_q)) * AW'(ROW_WORDS) +
			AW'(c_word_q));
	end

	// multiply sizes from the incoming command
	always_comb begin
		in_rows   = rows_eff(rows_cfg_q, cmd.tile);
		in_dbytes = bytes_eff(bytes_cfg_q, cmd.tile);
		in_abytes = bytes_eff(bytes_cfg_q, cmd.src_a);
		in_k      = (in_abytes[6:2] > 5'(TILE_ROWS)) ? 5'(TILE_ROWS) : in_abytes[6:2];
		in_mul_ok = tile_ok(cmd.tile) && tile_ok(cmd.src_a) && tile_ok(cmd.src_b);
	end

	assign cmd.ready = (state_q == S_IDLE);

	assign rsp.valid      = ov_q;
	assign rsp.read_data  = od_q;
	assign rsp.byte_valid = ob_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLR;
			clr_addr_q <= '0;
			clr_last_q <= AW'(DEPTH - 1);
			then_ld_q  <= 1'b0;
			c_tile_q   <= '0;
			c_row_q    <= '0;
			c_word_q   <= '0;
			c_data_q   <= '0;
			m_q        <= '0;
			mm_q       <= '0;
			nn_q       <= '0;
			kk_q       <= '0;
			b_base_q   <= '0;
			a_rb_q     <= '0;
			d_rb_q     <= '0;
			cp_q       <= '0;
			iw_q       <= '0;
			ik_q       <= '0;
			ov_q       <= 1'b0;
			od_q       <= '0;
			ob_q       <= '0;
		end else begin
			// S_RD_OUT refills the slot itself whenever it is taken
			if (rsp.ready && (state_q != S_RD_OUT)) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_addr_q <= clr_addr_q + AW'(1);
					if (clr_addr_q == clr_last_q) begin
						state_q <= then_ld_q ? S_LD_RD : S_IDLE;
					end
				end
				S_IDLE: if (cmd.valid) begin
					c_tile_q  <= cmd.tile;
					c_row_q   <= cmd.row;
					c_word_q  <= cmd.word;
					c_data_q  <= cmd.data;
					then_ld_q <= 1'b0;
					unique case (cmd.kind)
						i8tm_pkg::KIND_CLEAR_ALL: begin
							clr_addr_q <= '0;
							clr_last_q <= AW'(DEPTH - 1);
							state_q    <= S_CLR;
						end
						i8tm_pkg::KIND_ZERO_TILE: if (tile_ok(cmd.tile)) begin
							clr_addr_q <= tile_base(cmd.tile);
							clr_last_q <= tile_base(cmd.tile) + AW'(TILE_WORDS - 1);
							state_q    <= S_CLR;
						end
						i8tm_pkg::KIND_LOAD: if (tile_ok(cmd.tile)) begin
							// first word of a load from row zero wipes the tile
							if (cmd.load_start && (start_q == '0)) begin
								clr_addr_q <= tile_base(cmd.tile);
								clr_last_q <= tile_base(cmd.tile) + AW'(TILE_WORDS - 1);
								then_ld_q  <= 1'b1;
								state_q    <= S_CLR;
							end else begin
								state_q <= S_LD_RD;
							end
						end
						i8tm_pkg::KIND_READ: begin
							state_q <= S_RD_RD;
						end
						i8tm_pkg::KIND_MUL: if (in_mul_ok && (in_rows != '0)) begin
							m_q      <= '0;
							mm_q     <= in_rows;
							nn_q     <= in_dbytes[6:2];
							kk_q     <= in_k;
							b_base_q <= tile_base(cmd.src_b);
							a_rb_q   <= tile_base(cmd.src_a);
							d_rb_q   <= tile_base(cmd.tile);
							cp_q     <= '0;
							iw_q     <= '0;
							state_q  <= S_M_COPY;
						end
						default: ;
					endcase
				end
				S_LD_RD:  state_q <= S_LD_WR;
				S_LD_WR:  state_q <= S_IDLE;
				S_RD_RD:  state_q <= S_RD_OUT;
				S_RD_OUT: if (!ov_q || rsp.ready) begin
					ov_q    <= 1'b1;
					od_q    <= mem_rd_q & q_bmask;
					ob_q    <= q_mask;
					state_q <= S_IDLE;
				end
				// b snapshot so a dst that aliases b still sees old b rows
				S_M_COPY: begin
					cp_q <= cp_q + SW'(1);
					if (cp_q == SW'(TILE_WORDS - 1)) begin
						iw_q    <= '0;
						state_q <= S_M_AROW;
					end
				end
				S_M_AROW: begin
					iw_q <= iw_q + WW'(1);
					if (iw_q == WW'(ROW_WORDS - 1)) begin
						iw_q    <= '0;
						state_q <= S_M_DROW;
					end
				end
				S_M_DROW: begin
					iw_q <= iw_q + WW'(1);
					if (iw_q == WW'(ROW_WORDS - 1)) begin
						iw_q    <= '0;
						ik_q    <= '0;
						state_q <= (kk_q == '0) ? S_M_DRAIN : S_M_MAC;
					end
				end
				S_M_MAC: begin
					if (iw_q == WW'(ROW_WORDS - 1)) begin
						iw_q <= '0;
						if (5'(ik_q) == kk_q - 5'd1) begin
							state_q <= S_M_DRAIN;
						end else begin
							ik_q <= ik_q + RW'(1);
						end
					end else begin
						iw_q <= iw_q + WW'(1);
					end
				end
				S_M_DRAIN: begin
					iw_q    <= '0;
					state_q <= S_M_WB;
				end
				S_M_WB: begin
					iw_q <= iw_q + WW'(1);
					if (iw_q == WW'(ROW_WORDS - 1)) begin
						iw_q <= '0;
						if ((m_q + 5'd1) < mm_q) begin
							m_q     <= m_q + 5'd1;
							a_rb_q  <= a_rb_q + AW'(ROW_WORDS);
							d_rb_q  <= d_rb_q + AW'(ROW_WORDS);
							state_q <= S_M_AROW;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// tile memory ports
	always_comb begin
		case (state_q)
			S_M_COPY: mem_raddr = b_base_q + AW'(cp_q);
			S_M_AROW: mem_raddr = a_rb_q + AW'(iw_q);
			S_M_DROW: mem_raddr = d_rb_q + AW'(iw_q);
			default:  mem_raddr = q_addr;
		endcase
		sc_raddr = SW'(SW'(ik_q) * SW'(ROW_WORDS) + SW'(iw_q));

		mem_we    = 1'b0;
		mem_waddr = q_addr;
		mem_wdata = '0;
		case (state_q)
			S_CLR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_addr_q;
			end
			S_LD_WR: begin
				mem_we    = |q_mask;
				mem_wdata = (mem_rd_q & ~q_bmask) | (c_data_q & q_bmask);
			end
			S_M_WB: begin
				mem_we    = 1'b1;
				mem_waddr = d_rb_q + AW'(iw_q);
				mem_wdata = acc_word;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			tile_mem[mem_waddr] <= mem_wdata;
		end
		mem_rd_q <= tile_mem[mem_raddr];
	end

	// read tag, registered alongside the memory read
	always_comb begin
		tag_d.vld  = (state_q == S_M_COPY) || (state_q == S_M_AROW) ||
			(state_q == S_M_DROW) || (state_q == S_M_MAC);
		tag_d.ph   = state_q;
		tag_d.cidx = cp_q;
		tag_d.widx = iw_q;
		tag_d.k    = ik_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1 <= tag_d;
		end
	end

	// scratch copy of the b tile
	always_ff @(posedge clk) begin
		if (tag_s1.vld && (tag_s1.ph == S_M_COPY)) begin
			scratch_mem[tag_s1.cidx] <= mem_rd_q;
		end
		sc_rd_q <= scratch_mem[sc_raddr];
	end

	// accumulate: each b word covers two int32 columns of the dst row
	assign acc_sel  = (state_q == S_M_WB) ? iw_q : tag_s1.widx;
	assign acc_word = acc_q[acc_sel];
	assign a_grp    = tag_s1.k[0] ? a_row_q[WW'(tag_s1.k >> 1)][63:32]
		: a_row_q[WW'(tag_s1.k >> 1)][31:0];
	assign lo_ok    = 5'({tag_s1.widx, 1'b0}) < nn_q;
	assign hi_ok    = 5'({tag_s1.widx, 1'b1}) < nn_q;

	i8tm_dot u_dot (
		.a_grp  (a_grp),
		.b_word (sc_rd_q),
		.dot_lo (dot_lo),
		.dot_hi (dot_hi)
	);

	always_ff @(posedge clk) begin
		if (tag_s1.vld) begin
			case (tag_s1.ph)
				S_M_AROW: a_row_q[tag_s1.widx] <= mem_rd_q;
				S_M_DROW: acc_q[tag_s1.widx]   <= mem_rd_q;
				S_M_MAC: begin
					acc_q[tag_s1.widx] <= {
						hi_ok ? acc_word[63:32] + dot_hi : acc_word[63:32],
						lo_ok ? acc_word[31:0] + dot_lo : acc_word[31:0]
					};
				end
				default: ;
			endcase
		end
	end

endmodule

>>> design/i8tm_checker.sv
// ----------------------------------------------------------------------------
// i8tm_checker
// port-level checks of the int8 tile matmul unit
// ----------------------------------------------------------------------------
`include "int8_tile_matmul_unit_defines.svh"

module i8tm_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            cmd_ready,
	input logic                            rsp_valid,
	input logic                            rsp_ready,
	input logic [i8tm_pkg::DATA_W-1:0]     read_data,
	input logic [i8tm_pkg::MASK_W-1:0]     byte_valid
);

	// rsp beat stays until taken
	`I8TM_ASSERT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready |=> rsp_valid)
	// stalled rsp payload holds
	`I8TM_ASSERT(a_rsp_stable, clk, arst_n, rsp_valid && !rsp_ready |=> $stable(read_data) && $stable(byte_valid))
	// the clearing pass after reset keeps commands out
	`I8TM_ASSERT_NR(a_reset_clear, clk, !arst_n |=> !cmd_ready)
	// valid bytes always form a run from byte zero
	`I8TM_ASSERT(a_mask_run, clk, arst_n, rsp_valid |-> ((byte_valid & (byte_valid + 8'd1)) == 8'd0))

endmodule

bind int8_tile_matmul_unit i8tm_checker u_i8tm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.cmd_ready  (cmd.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.read_data  (rsp.read_data),
	.byte_valid (rsp.byte_valid)
);
